// File: rtl/vp8dir_pkg.sv
// Package for the VP8 descriptor id rewriter: transfer types and descriptor constants.
`timescale 1ns / 1ps

package vp8dir_pkg;

  // Shortest payload that is rewritten
  localparam logic [15:0] HdrBytes = 16'd6;

  // Bit positions inside the descriptor octets
  localparam int unsigned XBit = 7;  // byte 0: extension present
  localparam int unsigned IBit = 7;  // extension octet: picture id present
  localparam int unsigned LBit = 6;  // extension octet: TL0PICIDX present
  localparam int unsigned MBit = 7;  // picture id octet: 15-bit form

  // Mask of the 15-bit picture id
  localparam logic [15:0] PicId15Mask = 16'h7FFF;

  // One input transfer
  typedef struct packed {
    logic        switched;
    logic [15:0] packet_length;
    logic [7:0]  header_byte_0;
    logic [7:0]  header_byte_1;
    logic [7:0]  header_byte_2;
    logic [7:0]  header_byte_3;
    logic [7:0]  header_byte_4;
    logic [7:0]  header_byte_5;
  } in_item_t;

  // One result transfer
  typedef struct packed {
    logic [7:0]  out_byte_0;
    logic [7:0]  out_byte_1;
    logic [7:0]  out_byte_2;
    logic [7:0]  out_byte_3;
    logic [7:0]  out_byte_4;
    logic [7:0]  out_byte_5;
    logic        applied;
    logic [15:0] new_picture_id;
    logic [7:0]  new_tl0_index;
  } out_item_t;

endpackage

// File: rtl/vp8_descriptor_id_rewriter_unit.sv
// Top level of the VP8 descriptor id rewriter: input register, rewrite logic, result register.
// Registers: the input register, then the result register.
// Throughput: one packet header per cycle while the output is not stalled; the rewrite
// and both id updates sit in one combinational step between the input and result registers.
// Reset: rst_ni low clears both valid flags and all six id counters to zero.
`timescale 1ns / 1ps

module vp8_descriptor_id_rewriter_unit
  import vp8dir_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Pipeline registers
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // Id state
  logic [15:0] last_pic_q, base_in_pic_q, base_prev_pic_q;
  logic [15:0] last_pic_d, base_in_pic_d, base_prev_pic_d;
  logic [7:0]  last_tl_q, base_in_tl_q, base_prev_tl_q;
  logic [7:0]  last_tl_d, base_in_tl_d, base_prev_tl_d;

  // Handshake
  logic out_adv, s1_adv, in_xfer;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_stall_o = s1_valid_q && !out_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Descriptor decode
  logic        long_enough, has_x, has_i, has_m, has_l;
  logic [15:0] picid;
  logic [7:0]  tl0;
  logic [2:0]  tl_pos;
  logic [7:0]  b [6];

  // Rewrite of the registered header
  always_comb begin
    b[0] = s1_data_q.header_byte_0;
    b[1] = s1_data_q.header_byte_1;
    b[2] = s1_data_q.header_byte_2;
    b[3] = s1_data_q.header_byte_3;
    b[4] = s1_data_q.header_byte_4;
    b[5] = s1_data_q.header_byte_5;

    long_enough = s1_data_q.packet_length >= HdrBytes;
    has_x = b[0][XBit];
    has_i = has_x && b[1][IBit];
    has_l = has_x && b[1][LBit];
    has_m = has_i && b[2][MBit];

    // Picture id follows the extension octet
    if (has_m) begin
      picid = {b[2], b[3]} & PicId15Mask;
    end else if (has_i) begin
      picid = {9'd0, b[2][6:0]};
    end else begin
      picid = 16'd0;
    end

    // TL0PICIDX follows the picture id, if any
    if (has_m) begin
      tl_pos = 3'd4;
    end else if (has_i) begin
      tl_pos = 3'd3;
    end else begin
      tl_pos = 3'd2;
    end
    tl0 = has_l ? b[tl_pos] : 8'd0;

    // Rebase on a stream switch
    base_prev_pic_d = base_prev_pic_q;
    base_in_pic_d   = base_in_pic_q;
    base_prev_tl_d  = base_prev_tl_q;
    base_in_tl_d    = base_in_tl_q;
    if (s1_data_q.switched) begin
      base_prev_pic_d = last_pic_q;
      base_in_pic_d   = picid;
      base_prev_tl_d  = last_tl_q;
      base_in_tl_d    = tl0;
    end

    // Continuous numbering, wrapping at the field width
    last_pic_d = long_enough ? picid - base_in_pic_d + base_prev_pic_d + 16'd1 : last_pic_q;
    last_tl_d  = long_enough ? tl0 - base_in_tl_d + base_prev_tl_d + 8'd1 : last_tl_q;

    // Write the new values back
    if (long_enough) begin
      if (has_m) begin
        b[2] = {1'b1, last_pic_d[14:8]};
        b[3] = last_pic_d[7:0];
      end else if (has_i) begin
        b[2] = {1'b0, last_pic_d[6:0]};
      end
      if (has_l) begin
        b[tl_pos] = last_tl_d;
      end
    end

    out_data_d.out_byte_0     = b[0];
    out_data_d.out_byte_1     = b[1];
    out_data_d.out_byte_2     = b[2];
    out_data_d.out_byte_3     = b[3];
    out_data_d.out_byte_4     = b[4];
    out_data_d.out_byte_5     = b[5];
    out_data_d.applied        = long_enough;
    out_data_d.new_picture_id = long_enough ? last_pic_d : 16'd0;
    out_data_d.new_tl0_index  = long_enough ? last_tl_d : 8'd0;
  end

  // Valid flags next values
  always_comb begin
    s1_valid_d  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (out_adv ? 1'b0 : out_valid_q);
  end

  // Control and id state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      out_valid_q     <= 1'b0;
      last_pic_q      <= 16'd0;
      base_in_pic_q   <= 16'd0;
      base_prev_pic_q <= 16'd0;
      last_tl_q       <= 8'd0;
      base_in_tl_q    <= 8'd0;
      base_prev_tl_q  <= 8'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv && out_data_d.applied) begin
        last_pic_q      <= last_pic_d;
        base_in_pic_q   <= base_in_pic_d;
        base_prev_pic_q <= base_prev_pic_d;
        last_tl_q       <= last_tl_d;
        base_in_tl_q    <= base_in_tl_d;
        base_prev_tl_q  <= base_prev_tl_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // Stall toward the source only while an item waits in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  // Short packets report zero ids
  a_short_zero_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.applied) |->
      (out_data_q.new_picture_id == 16'd0 && out_data_q.new_tl0_index == 8'd0))
    else $error("short packet carries nonzero ids");

  // A shown applied result is the latest state
  a_state_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.applied) |->
      (last_pic_q == out_data_q.new_picture_id && last_tl_q == out_data_q.new_tl0_index))
    else $error("id state out of step with result register");

  // A result held under stall stays valid and the id state does not advance
  a_hold_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(last_pic_q)))
    else $error("state advanced while result stalled");
`endif

endmodule
